// ----- sv/ldtw_pkg.sv -----
package ldtw_pkg;

    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 3;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 8;
    localparam int unsigned FrameW   = 16;
    localparam int unsigned BitIdxW  = 4;

    localparam logic [7:0] AddrBase = 8'hC0;
    localparam logic [7:0] CtrlBase = 8'h80;

    localparam logic [CfgIdxW-1:0] CFG_DISPLAY_ON = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS = 1'd1;

    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_DIGIT   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_A,
        ST_START_B,
        ST_BIT_SET,
        ST_BIT_HIGH,
        ST_BIT_LOW,
        ST_STOP_A,
        ST_STOP_B,
        ST_STOP_C
    } ldtw_state_t;

    typedef enum logic [1:0] {
        PIN_LOW,
        PIN_HIGH,
        PIN_KEEP,
        PIN_BIT
    } ldtw_pin_sel_t;

    typedef struct packed {
        logic          load;
        logic          emit;
        logic          advance;
        logic          last;
        ldtw_pin_sel_t clk_sel;
        ldtw_pin_sel_t dio_sel;
    } ldtw_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_bit;
    } ldtw_stat_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// ----- sv/ldtw_ctrl.sv -----
module ldtw_ctrl
    import ldtw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ldtw_stat_t stat,
    output ldtw_cmd_t  cmd
);

    ldtw_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.clk_sel = PIN_LOW;
        cmd.dio_sel = PIN_LOW;
        s_tready    = 1'b0;
        cmd.emit    = (state_reg != ST_IDLE) && stat.out_free;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START_A;
                end
            end
            ST_START_A: begin
                cmd.clk_sel = PIN_KEEP;
                if (stat.out_free) state_next = ST_START_B;
            end
            ST_START_B: begin
                if (stat.out_free) state_next = ST_BIT_SET;
            end
            ST_BIT_SET: begin
                cmd.dio_sel = PIN_BIT;
                if (stat.out_free) state_next = ST_BIT_HIGH;
            end
            ST_BIT_HIGH: begin
                cmd.clk_sel = PIN_HIGH;
                cmd.dio_sel = PIN_BIT;
                if (stat.out_free) state_next = ST_BIT_LOW;
            end
            ST_BIT_LOW: begin
                cmd.dio_sel = PIN_BIT;
                cmd.advance = stat.out_free;
                if (stat.out_free) begin
                    state_next = stat.last_bit ? ST_STOP_A : ST_BIT_SET;
                end
            end
            ST_STOP_A: begin
                if (stat.out_free) state_next = ST_STOP_B;
            end
            ST_STOP_B: begin
                cmd.clk_sel = PIN_HIGH;
                if (stat.out_free) state_next = ST_STOP_C;
            end
            ST_STOP_C: begin
                cmd.clk_sel = PIN_HIGH;
                cmd.dio_sel = PIN_HIGH;
                cmd.last    = 1'b1;
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("frame did not end after last beat");

    a_load_starts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_START_A))
        else $error("load did not start a frame");

endmodule

// ----- sv/ldtw_dp.sv -----
module ldtw_dp
    import ldtw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                kind,
    input  logic [3:0]          position,
    input  logic [3:0]          digit,
    input  ldtw_cmd_t           cmd,
    output ldtw_stat_t          stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tlast
);

    logic               display_on_reg;
    logic [2:0]         brightness_reg;
    logic [FrameW-1:0]  frame_reg;
    logic               wide_reg;
    logic [BitIdxW-1:0] bit_idx_reg;
    logic               clk_pin_reg;
    logic               m_valid_reg;
    logic               m_clk_reg;
    logic               m_dio_reg;
    logic               m_last_reg;

    logic               cur_bit;
    logic               clk_next;
    logic               dio_next;
    logic [FrameW-1:0]  frame_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_on_reg <= 1'b1;
            brightness_reg <= 3'd7;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DISPLAY_ON: display_on_reg <= cfg_wdata[0];
                CFG_BRIGHTNESS: brightness_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (kind == KIND_DIGIT) begin
            frame_next = {seg_pattern(digit), AddrBase + {4'd0, position}};
        end else begin
            frame_next = {8'h00, CtrlBase | {4'd0, display_on_reg, brightness_reg}};
        end
    end

    assign cur_bit       = frame_reg[bit_idx_reg];
    assign stat.last_bit = wide_reg ? (bit_idx_reg == 4'd15) : (bit_idx_reg == 4'd7);
    assign stat.out_free = !m_valid_reg || m_tready;

    always_comb begin
        unique case (cmd.clk_sel)
            PIN_LOW:  clk_next = 1'b0;
            PIN_HIGH: clk_next = 1'b1;
            PIN_KEEP: clk_next = clk_pin_reg;
            PIN_BIT:  clk_next = cur_bit;
            default:  clk_next = 1'b0;
        endcase
        unique case (cmd.dio_sel)
            PIN_LOW:  dio_next = 1'b0;
            PIN_HIGH: dio_next = 1'b1;
            PIN_BIT:  dio_next = cur_bit;
            default:  dio_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            frame_reg <= frame_next;
            wide_reg  <= (kind == KIND_DIGIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_idx_reg <= '0;
            clk_pin_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                bit_idx_reg <= '0;
            end else if (cmd.advance) begin
                bit_idx_reg <= bit_idx_reg + 1'b1;
            end
            if (cmd.emit) begin
                clk_pin_reg <= clk_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_clk_reg  <= clk_next;
            m_dio_reg  <= dio_next;
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_dio_reg, m_clk_reg};
    assign m_tlast  = m_last_reg;

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("beat emitted over a held beat");

    a_last_idles_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_clk_reg && m_dio_reg))
        else $error("frame did not end with both pins high");

endmodule

// ----- sv/led_driver_two_wire_frame_sender.sv -----
// Channel | Ports                         | Beat contents
// input   | s_tvalid s_tready s_tdata s_tuser | one command (control frame or digit write)
// output  | m_tvalid m_tready m_tdata m_tlast | one pin change of the serial frame
// config  | cfg_we cfg_index cfg_wdata    | 0: display_on, 1: brightness
//
// A command is loaded from the idle state, then one pin change is emitted per cycle
// while m_tready does not stall the output.
// The frame sequencer accepts the next command once the last beat is registered.
// Reset is synchronous, active low; pins idle high, display_on=1, brightness=7.
// A stalled m_tready holds the sequencer on the current pin change.
module led_driver_two_wire_frame_sender
    import ldtw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [3:0] position, [7:4] digit
    input  logic                s_tuser,   // [0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // [0] clk_level, [1] dio_level, [7:2] zero
    output logic                m_tlast
);

    ldtw_cmd_t  cmd;
    ldtw_stat_t stat;

    ldtw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ldtw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .kind      (s_tuser),
        .position  (s_tdata[3:0]),
        .digit     (s_tdata[7:4]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- tb/tb_led_driver_two_wire_frame_sender.sv -----
module tb_led_driver_two_wire_frame_sender;
    import ldtw_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [3:0] position;
        logic [3:0] digit;
    } led_cmd_t;

    typedef struct packed {
        logic clk_lvl;
        logic dio_lvl;
        logic last;
    } pin_beat_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tlast;

    led_driver_two_wire_frame_sender u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic       disp_on_cfg = 1'b1;
    logic [2:0] bright_cfg  = 3'd7;
    logic       pin_clk     = 1'b1;
    logic       pin_dio     = 1'b1;
    logic [7:0] seg_lut [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                  8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    led_cmd_t  cmd_backlog [$];
    pin_beat_t pin_changes_due [$];
    led_cmd_t  cmd_on_bus;

    int  fault_count     = 0;
    int  tx_gap          = 0;
    int  rx_stall        = 0;
    int  rx_beats        = 0;
    bit  long_hold_done  = 1'b0;
    bit  quiet           = 1'b0;

    task automatic add_pin(input logic c, input logic d, input logic l);
        pin_beat_t b;
        b.clk_lvl = c;
        b.dio_lvl = d;
        b.last    = l;
        pin_clk   = c;
        pin_dio   = d;
        pin_changes_due.push_back(b);
    endtask

    task automatic queue_frame_pins(input led_cmd_t c);
        logic [15:0] bits;
        int          nbits;
        if (c.kind == KIND_CONTROL) begin
            bits  = {8'h00, CtrlBase | {4'b0000, disp_on_cfg, bright_cfg}};
            nbits = 8;
        end else begin
            bits  = {(c.digit < 4'd10) ? seg_lut[c.digit] : 8'h00,
                     AddrBase + {4'b0000, c.position}};
            nbits = 16;
        end
        // start condition
        add_pin(pin_clk, 1'b0, 1'b0);
        add_pin(1'b0, 1'b0, 1'b0);
        for (int i = 0; i < nbits; i++) begin
            add_pin(1'b0, bits[i], 1'b0);
            add_pin(1'b1, bits[i], 1'b0);
            add_pin(1'b0, bits[i], 1'b0);
        end
        // stop condition
        add_pin(1'b0, 1'b0, 1'b0);
        add_pin(1'b1, 1'b0, 1'b0);
        add_pin(1'b1, 1'b1, 1'b1);
    endtask

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                queue_frame_pins(cmd_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap   = tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {cmd_on_bus.digit, cmd_on_bus.position};
                    s_tuser    <= cmd_on_bus.kind;
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        tx_gap = $urandom_range(1, 14);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // pin beat monitor
    always @(posedge aclk) begin
        pin_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_beats = rx_beats + 1;
                if (pin_changes_due.size() == 0) begin
                    fault_count = fault_count + 1;
                    $display("%0t: unexpected pin beat: expected none, actual tdata=%h last=%b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = pin_changes_due.pop_front();
                    if (m_tdata !== {6'b000000, want.dio_lvl, want.clk_lvl} ||
                        m_tlast !== want.last) begin
                        fault_count = fault_count + 1;
                        $display("%0t: pin beat mismatch: expected clk=%b dio=%b last=%b, %s",
                                 $time, want.clk_lvl, want.dio_lvl, want.last, "actual:");
                        $display("%0t:   actual clk=%b dio=%b pad=%b last=%b",
                                 $time, m_tdata[0], m_tdata[1], m_tdata[7:2], m_tlast);
                    end
                end
            end
            // one long hold-off so the sequencer backs up into the input
            if (!long_hold_done && rx_beats >= 3000 && s_tvalid && !s_tready) begin
                long_hold_done = 1'b1;
                rx_stall       = 600;
            end
            if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                rx_stall = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input logic k, input logic [3:0] p, input logic [3:0] d);
        led_cmd_t c;
        c.kind     = k;
        c.position = p;
        c.digit    = d;
        cmd_backlog.push_back(c);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DISPLAY_ON) begin
            disp_on_cfg = val[0];
        end else begin
            bright_cfg = val;
        end
        @(negedge aclk);
    endtask

    task automatic drain;
        while (cmd_backlog.size() != 0 || s_tvalid || pin_changes_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic [2:0] v;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, every digit pattern, blanks, grid extremes
        push_cmd(KIND_CONTROL, 4'hF, 4'hF);
        push_cmd(KIND_DIGIT, 4'd0, 4'd0);
        push_cmd(KIND_DIGIT, 4'd15, 4'd9);
        for (int i = 1; i <= 8; i++) begin
            push_cmd(KIND_DIGIT, i[3:0], i[3:0]);
        end
        for (int i = 10; i <= 15; i++) begin
            push_cmd(KIND_DIGIT, i[3:0], i[3:0]);
        end
        push_cmd(KIND_CONTROL, 4'h0, 4'h0);
        drain();

        cfg_write(CFG_DISPLAY_ON, 3'b110);
        cfg_write(CFG_BRIGHTNESS, 3'd0);
        @(negedge aclk);
        push_cmd(KIND_CONTROL, 4'h5, 4'hA);
        push_cmd(KIND_DIGIT, 4'd15, 4'd15);
        drain();

        cfg_write(CFG_DISPLAY_ON, 3'b001);
        @(negedge aclk);
        push_cmd(KIND_CONTROL, 4'h0, 4'h0);
        drain();

        cfg_write(CFG_DISPLAY_ON, 3'b000);
        cfg_write(CFG_BRIGHTNESS, 3'd7);
        @(negedge aclk);
        push_cmd(KIND_CONTROL, 4'hA, 4'h5);
        drain();

        // random phases, each under its own settings
        for (int ph = 0; ph < 10; ph++) begin
            v = 3'($urandom_range(0, 7));
            if (ph == 0) v[0] = 1'b0;
            if (ph == 1) v[0] = 1'b1;
            cfg_write(CFG_DISPLAY_ON, v);
            v = 3'($urandom_range(0, 7));
            if (ph == 0) v = 3'd0;
            if (ph == 1) v = 3'd7;
            cfg_write(CFG_BRIGHTNESS, v);
            quiet = (ph >= 8);
            @(negedge aclk);
            for (int n = 0; n < 26; n++) begin
                push_cmd(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)));
            end
            drain();
        end

        repeat (60) @(posedge aclk);
        if (pin_changes_due.size() != 0) begin
            fault_count = fault_count + 1;
            $display("%0t: pin beats missing: expected %0d more, actual 0",
                     $time, pin_changes_due.size());
        end
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
